@@ sv/i2cem_pkg.sv @@
`default_nettype none

package i2cem_pkg;

   // command codes on the func field
   localparam logic [1:0] FUNC_WRITE   = 2'd0;
   localparam logic [1:0] FUNC_READ    = 2'd1;
   localparam logic [1:0] FUNC_RECOVER = 2'd2;

   // register map: index taken from the word address
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        CSR_DEVICE_ADDRESS = 1'b0;

   // reset value of the device address, write form
   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'hA0;

   // high address byte sent ahead of the word address
   localparam logic [7:0] HIGH_ADDR_BYTE = 8'h00;

   // byte positions in the address phase
   localparam logic [2:0] BYTE_DEVICE = 3'd0;
   localparam logic [2:0] BYTE_HIGH   = 3'd1;
   localparam logic [2:0] BYTE_WORD   = 3'd2;
   localparam logic [2:0] BYTE_LAST   = 3'd3;

   // quarter-bit positions within one bus slot
   localparam logic [1:0] Q_FIRST = 2'd0;
   localparam logic [1:0] Q_RISE  = 2'd1;
   localparam logic [1:0] Q_SAMP  = 2'd2;
   localparam logic [1:0] Q_LAST  = 2'd3;

   // bits per byte on the bus
   localparam int unsigned BITS_PER_BYTE = 8;

endpackage

`default_nettype wire

@@ sv/i2c_eeprom_master_top.sv @@
`default_nettype none

// I2C master for a serial EEPROM: byte write, random read and bus recovery. Every req_ transfer
// is one quarter-bit tick of the bus timebase, so a bus bit takes four transfers; drive one
// transfer per tick with req_sda_in holding the sampled SDA level. The block takes one transfer
// per clock cycle unless stalled. Each transfer yields exactly one rsp_ transfer with the SCL
// level, the SDA pull-down and the status for that tick; it is registered the cycle after the
// req_ transfer, and req_stall rises only while a held result is stalled by rsp_stall. A
// command (req_cmd_valid with func write, read or recover) starts a sequence only while idle;
// busy and done report its progress, read_data holds the last byte read and ack_missing flags a
// slave ack slot that saw SDA high. Write device_address through the register port while idle.
module i2c_eeprom_master_top #(
   parameter int unsigned RECOVERY_TOGGLES = 10
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // command and tick channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_cmd_valid,
   input  wire logic [1:0]                            req_func,
   input  wire logic [7:0]                            req_word_addr,
   input  wire logic [7:0]                            req_write_data,
   input  wire logic                                  req_sda_in,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_scl_level,
   output logic                                       rsp_sda_pull_low,
   output logic                                       rsp_busy_res,
   output logic                                       rsp_done_res,
   output logic [7:0]                                 rsp_read_data,
   output logic                                       rsp_ack_missing,
   // register port
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [i2cem_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [31:0]                           pwdata,
   output logic [31:0]                                prdata,
   output logic                                       pready
);

   // bit counter must reach both a byte and the recovery toggle count
   localparam int unsigned TOG_W = $clog2(RECOVERY_TOGGLES + 1);
   localparam int unsigned CNT_W = (TOG_W > 4) ? TOG_W : 4;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_SEND,
      PH_ACK,
      PH_READ,
      PH_NOACK,
      PH_STOP,
      PH_TOGGLE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [2:0]       byte_index_ff, byte_index_in;
   logic [CNT_W-1:0] bit_count_ff, bit_count_in;
   logic [1:0]       quarter_ff, quarter_in;
   logic [7:0]       shift_reg_ff, shift_reg_in;
   logic [1:0]       saved_func_ff, saved_func_in;
   logic [7:0]       saved_addr_ff, saved_addr_in;
   logic [7:0]       saved_data_ff, saved_data_in;
   logic [7:0]       read_reg_ff, read_reg_in;
   logic             ack_flag_ff, ack_flag_in;
   logic [7:0]       device_address_ff;

   logic             rsp_valid_ff;
   logic             scl_ff, scl_in;
   logic             pull_ff, pull_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic             req_take;
   logic             rsp_take;
   logic             csr_write;

   // handshake: stall only while the held result cannot leave
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign rsp_take  = rsp_valid_ff & ~rsp_stall;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign prdata    = (paddr[2] == i2cem_pkg::CSR_DEVICE_ADDRESS) ?
                      {24'd0, device_address_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= i2cem_pkg::DEVICE_ADDRESS_RESET;
      end else if (csr_write && paddr[2] == i2cem_pkg::CSR_DEVICE_ADDRESS) begin
         device_address_ff <= pwdata[7:0];
      end
   end

   // one tick: command capture, slot drive, then slot advance
   always_comb begin
      logic mid;
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      bit_count_in  = bit_count_ff;
      quarter_in    = quarter_ff;
      shift_reg_in  = shift_reg_ff;
      saved_func_in = saved_func_ff;
      saved_addr_in = saved_addr_ff;
      saved_data_in = saved_data_ff;
      read_reg_in   = read_reg_ff;
      ack_flag_in   = ack_flag_ff;
      scl_in        = 1'b1;
      pull_in       = 1'b0;
      busy_in       = 1'b0;
      done_in       = 1'b0;

      // command capture while idle
      if (phase_ff == PH_IDLE && req_cmd_valid && req_func <= i2cem_pkg::FUNC_RECOVER) begin
         saved_func_in = req_func;
         saved_addr_in = req_word_addr;
         saved_data_in = req_write_data;
         ack_flag_in   = 1'b0;
         byte_index_in = i2cem_pkg::BYTE_DEVICE;
         bit_count_in  = '0;
         quarter_in    = i2cem_pkg::Q_FIRST;
         phase_in      = PH_START;
      end

      mid = (quarter_in == i2cem_pkg::Q_RISE) || (quarter_in == i2cem_pkg::Q_SAMP);

      if (phase_in != PH_IDLE) begin
         busy_in = 1'b1;

         // bus drive for this quarter
         case (phase_in)
            PH_START: begin
               if (quarter_in == i2cem_pkg::Q_FIRST) begin
                  scl_in = (byte_index_in == i2cem_pkg::BYTE_DEVICE);
               end else begin
                  scl_in = (quarter_in != i2cem_pkg::Q_LAST);
               end
               pull_in = quarter_in[1];
            end
            PH_SEND: begin
               scl_in  = mid;
               pull_in = ~shift_reg_in[7];
            end
            PH_ACK: begin
               scl_in = mid;
               if (quarter_in == i2cem_pkg::Q_SAMP && req_sda_in) begin
                  ack_flag_in = 1'b1;
               end
            end
            PH_READ: begin
               scl_in = mid;
               if (quarter_in == i2cem_pkg::Q_SAMP) begin
                  shift_reg_in = {shift_reg_in[6:0], req_sda_in};
               end
            end
            PH_NOACK: begin
               scl_in = mid;
            end
            PH_STOP: begin
               scl_in  = (quarter_in != i2cem_pkg::Q_FIRST);
               pull_in = ~quarter_in[1];
               done_in = (quarter_in == i2cem_pkg::Q_LAST);
            end
            default: begin
               scl_in = ~bit_count_in[0];
            end
         endcase

         // slot advance at the end of the last quarter
         if (quarter_in == i2cem_pkg::Q_LAST) begin
            quarter_in = i2cem_pkg::Q_FIRST;
            case (phase_in)
               PH_START: begin
                  if (saved_func_in == i2cem_pkg::FUNC_RECOVER) begin
                     bit_count_in = '0;
                     phase_in     = (byte_index_in == i2cem_pkg::BYTE_DEVICE) ?
                                    PH_TOGGLE : PH_STOP;
                  end else begin
                     shift_reg_in = (byte_index_in == i2cem_pkg::BYTE_LAST) ?
                                    8'(device_address_ff + 8'd1) : device_address_ff;
                     bit_count_in = '0;
                     phase_in     = PH_SEND;
                  end
               end
               PH_SEND: begin
                  shift_reg_in = {shift_reg_in[6:0], 1'b0};
                  bit_count_in = CNT_W'(bit_count_in + 1'b1);
                  if (bit_count_in >= CNT_W'(i2cem_pkg::BITS_PER_BYTE)) begin
                     bit_count_in = '0;
                     phase_in     = PH_ACK;
                  end
               end
               PH_ACK: begin
                  case (byte_index_in)
                     i2cem_pkg::BYTE_DEVICE: begin
                        byte_index_in = i2cem_pkg::BYTE_HIGH;
                        shift_reg_in  = i2cem_pkg::HIGH_ADDR_BYTE;
                        bit_count_in  = '0;
                        phase_in      = PH_SEND;
                     end
                     i2cem_pkg::BYTE_HIGH: begin
                        byte_index_in = i2cem_pkg::BYTE_WORD;
                        shift_reg_in  = saved_addr_in;
                        bit_count_in  = '0;
                        phase_in      = PH_SEND;
                     end
                     i2cem_pkg::BYTE_WORD: begin
                        byte_index_in = i2cem_pkg::BYTE_LAST;
                        if (saved_func_in == i2cem_pkg::FUNC_READ) begin
                           phase_in = PH_START;
                        end else begin
                           shift_reg_in = saved_data_in;
                           bit_count_in = '0;
                           phase_in     = PH_SEND;
                        end
                     end
                     default: begin
                        if (saved_func_in == i2cem_pkg::FUNC_READ) begin
                           bit_count_in = '0;
                           shift_reg_in = 8'd0;
                           phase_in     = PH_READ;
                        end else begin
                           phase_in = PH_STOP;
                        end
                     end
                  endcase
               end
               PH_READ: begin
                  bit_count_in = CNT_W'(bit_count_in + 1'b1);
                  if (bit_count_in >= CNT_W'(i2cem_pkg::BITS_PER_BYTE)) begin
                     bit_count_in = '0;
                     read_reg_in  = shift_reg_in;
                     phase_in     = PH_NOACK;
                  end
               end
               PH_NOACK: begin
                  phase_in = PH_STOP;
               end
               PH_TOGGLE: begin
                  bit_count_in = CNT_W'(bit_count_in + 1'b1);
                  if (bit_count_in >= CNT_W'(RECOVERY_TOGGLES)) begin
                     bit_count_in  = '0;
                     byte_index_in = i2cem_pkg::BYTE_HIGH;
                     phase_in      = PH_START;
                  end
               end
               default: begin
                  // stop finished: back to idle
                  phase_in      = PH_IDLE;
                  byte_index_in = i2cem_pkg::BYTE_DEVICE;
                  bit_count_in  = '0;
               end
            endcase
         end else begin
            quarter_in = 2'(quarter_in + 2'd1);
         end
      end
   end

   // sequencer state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         byte_index_ff <= i2cem_pkg::BYTE_DEVICE;
         bit_count_ff  <= '0;
         quarter_ff    <= i2cem_pkg::Q_FIRST;
         read_reg_ff   <= 8'd0;
         ack_flag_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff      <= phase_in;
            byte_index_ff <= byte_index_in;
            bit_count_ff  <= bit_count_in;
            quarter_ff    <= quarter_in;
            read_reg_ff   <= read_reg_in;
            ack_flag_ff   <= ack_flag_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
      if (req_take) begin
         shift_reg_ff  <= shift_reg_in;
         saved_func_ff <= saved_func_in;
         saved_addr_ff <= saved_addr_in;
         saved_data_ff <= saved_data_in;
         scl_ff        <= scl_in;
         pull_ff       <= pull_in;
         busy_ff       <= busy_in;
         done_ff       <= done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_level    = scl_ff;
   assign rsp_sda_pull_low = pull_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_read_data    = read_reg_ff;
   assign rsp_ack_missing  = ack_flag_ff;

   // a completing tick is always a busy tick
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> busy_ff)
      else $error("done reported without busy");

   // idle always sits at the start of a slot
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> quarter_ff == i2cem_pkg::Q_FIRST)
      else $error("idle with a partial slot");

   // byte shifting never runs past eight bits
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SEND || phase_ff == PH_READ |->
         bit_count_ff < CNT_W'(i2cem_pkg::BITS_PER_BYTE))
      else $error("bit count past byte end");

   // every accepted tick leaves a result in the output register
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("tick transfer lost its result");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned RECOVERY_TOGGLES = 10;
   localparam int unsigned CYCLE_LIMIT      = 600000;
   localparam int unsigned PHASE_BUDGET     = 100;
   localparam logic [1:0]  FUNC_UNUSED      = 2'd3;

   typedef enum logic [2:0] {
      BUS_IDLE, BUS_START, BUS_SEND, BUS_ACK, BUS_READ, BUS_NOACK, BUS_STOP, BUS_TOGGLE
   } bus_phase_type;

   // how the slave side drives sda during one sequence
   typedef enum logic [1:0] {SDA_LOW, SDA_MOSTLY_LOW, SDA_RANDOM, SDA_HIGH} sda_mode_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] func;
      logic [7:0] word_addr;
      logic [7:0] write_data;
      logic       sda_in;
   } tick_type;

   typedef struct packed {
      logic       scl;
      logic       pull;
      logic       busy;
      logic       done;
      logic [7:0] rdata;
      logic       ack;
   } bus_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd_valid = 1'b0;
   logic [1:0]  req_func = '0;
   logic [7:0]  req_word_addr = '0;
   logic [7:0]  req_write_data = '0;
   logic        req_sda_in = 1'b1;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_pull_low;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_data;
   logic        rsp_ack_missing;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [i2cem_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   i2c_eeprom_master_top #(
      .RECOVERY_TOGGLES(RECOVERY_TOGGLES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd_valid    (req_cmd_valid),
      .req_func         (req_func),
      .req_word_addr    (req_word_addr),
      .req_write_data   (req_write_data),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_level    (rsp_scl_level),
      .rsp_sda_pull_low (rsp_sda_pull_low),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_data    (rsp_read_data),
      .rsp_ack_missing  (rsp_ack_missing),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // pending ticks and expected bus outputs
   tick_type    tick_queue[$];
   bus_out_type bus_expect_q[$];
   int unsigned ticks_pushed = 0;
   int unsigned results_seen = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   logic        calm = 1'b0;

   // coverage tallies for the summary
   int unsigned n_write = 0;
   int unsigned n_read = 0;
   int unsigned n_recover = 0;
   int unsigned n_ignored = 0;
   int unsigned n_settings = 0;

   // bus master model state
   logic [7:0]    dev_addr_model = i2cem_pkg::DEVICE_ADDRESS_RESET;
   bus_phase_type ph = BUS_IDLE;
   logic [2:0]    byte_idx = '0;
   logic [5:0]    bit_cnt = '0;
   logic [1:0]    qtr = '0;
   logic [7:0]    shreg = '0;
   logic [1:0]    s_func = '0;
   logic [7:0]    s_addr = '0;
   logic [7:0]    s_data = '0;
   logic [7:0]    rd_reg = '0;
   logic          ack_miss = 1'b0;

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      fail_count++;
      $display("mismatch at result %0d: %s got %0h expected %0h",
               results_seen, what, got, want);
   endtask

   task automatic check_field(input string what, input int unsigned got,
                              input int unsigned want);
      if (got != want) flag_mismatch(what, got, want);
   endtask

   // advance the model by one quarter-bit tick
   task automatic predict_tick(input tick_type t, output bus_out_type o);
      logic mid;
      o = '0;
      o.scl = 1'b1;
      // command start, only from idle with a known function
      if (t.cmd_valid && (ph != BUS_IDLE || t.func == FUNC_UNUSED)) n_ignored++;
      if (ph == BUS_IDLE && t.cmd_valid && t.func != FUNC_UNUSED) begin
         case (t.func)
            i2cem_pkg::FUNC_WRITE: n_write++;
            i2cem_pkg::FUNC_READ:  n_read++;
            default:               n_recover++;
         endcase
         s_func   = t.func;
         s_addr   = t.word_addr;
         s_data   = t.write_data;
         ack_miss = 1'b0;
         byte_idx = i2cem_pkg::BYTE_DEVICE;
         bit_cnt  = '0;
         qtr      = i2cem_pkg::Q_FIRST;
         ph       = BUS_START;
      end
      if (ph != BUS_IDLE) begin
         mid = (qtr == i2cem_pkg::Q_RISE || qtr == i2cem_pkg::Q_SAMP);
         o.busy = 1'b1;
         // line levels for this quarter
         case (ph)
            BUS_START: begin
               if (qtr == i2cem_pkg::Q_FIRST) o.scl = (byte_idx == i2cem_pkg::BYTE_DEVICE);
               else o.scl = (qtr != i2cem_pkg::Q_LAST);
               o.pull = (qtr == i2cem_pkg::Q_SAMP || qtr == i2cem_pkg::Q_LAST);
            end
            BUS_SEND: begin
               o.scl  = mid;
               o.pull = ~shreg[7];
            end
            BUS_ACK: begin
               o.scl = mid;
               if (qtr == i2cem_pkg::Q_SAMP && t.sda_in) ack_miss = 1'b1;
            end
            BUS_READ: begin
               o.scl = mid;
               if (qtr == i2cem_pkg::Q_SAMP) shreg = {shreg[6:0], t.sda_in};
            end
            BUS_NOACK: o.scl = mid;
            BUS_STOP: begin
               o.scl  = (qtr != i2cem_pkg::Q_FIRST);
               o.pull = (qtr == i2cem_pkg::Q_FIRST || qtr == i2cem_pkg::Q_RISE);
               o.done = (qtr == i2cem_pkg::Q_LAST);
            end
            default: o.scl = ~bit_cnt[0];
         endcase
         // slot sequencing at the end of each bit
         if (qtr == i2cem_pkg::Q_LAST) begin
            qtr = i2cem_pkg::Q_FIRST;
            case (ph)
               BUS_START: begin
                  bit_cnt = '0;
                  if (s_func == i2cem_pkg::FUNC_RECOVER) begin
                     ph = (byte_idx == i2cem_pkg::BYTE_DEVICE) ? BUS_TOGGLE : BUS_STOP;
                  end else begin
                     shreg = (byte_idx == i2cem_pkg::BYTE_LAST) ?
                             8'(dev_addr_model + 8'd1) : dev_addr_model;
                     ph = BUS_SEND;
                  end
               end
               BUS_SEND: begin
                  shreg   = {shreg[6:0], 1'b0};
                  bit_cnt = bit_cnt + 1'b1;
                  if (bit_cnt >= i2cem_pkg::BITS_PER_BYTE) begin
                     bit_cnt = '0;
                     ph = BUS_ACK;
                  end
               end
               BUS_ACK: begin
                  bit_cnt = '0;
                  if (byte_idx == i2cem_pkg::BYTE_DEVICE) begin
                     byte_idx = i2cem_pkg::BYTE_HIGH;
                     shreg = i2cem_pkg::HIGH_ADDR_BYTE;
                     ph = BUS_SEND;
                  end else if (byte_idx == i2cem_pkg::BYTE_HIGH) begin
                     byte_idx = i2cem_pkg::BYTE_WORD;
                     shreg = s_addr;
                     ph = BUS_SEND;
                  end else if (byte_idx == i2cem_pkg::BYTE_WORD) begin
                     byte_idx = i2cem_pkg::BYTE_LAST;
                     if (s_func == i2cem_pkg::FUNC_READ) begin
                        ph = BUS_START;
                     end else begin
                        shreg = s_data;
                        ph = BUS_SEND;
                     end
                  end else if (s_func == i2cem_pkg::FUNC_READ) begin
                     shreg = '0;
                     ph = BUS_READ;
                  end else begin
                     ph = BUS_STOP;
                  end
               end
               BUS_READ: begin
                  bit_cnt = bit_cnt + 1'b1;
                  if (bit_cnt >= i2cem_pkg::BITS_PER_BYTE) begin
                     bit_cnt = '0;
                     rd_reg = shreg;
                     ph = BUS_NOACK;
                  end
               end
               BUS_NOACK: ph = BUS_STOP;
               BUS_TOGGLE: begin
                  bit_cnt = bit_cnt + 1'b1;
                  if (bit_cnt >= RECOVERY_TOGGLES) begin
                     bit_cnt = '0;
                     byte_idx = i2cem_pkg::BYTE_HIGH;
                     ph = BUS_START;
                  end
               end
               default: begin
                  ph = BUS_IDLE;
                  byte_idx = i2cem_pkg::BYTE_DEVICE;
                  bit_cnt = '0;
               end
            endcase
         end else begin
            qtr = qtr + 1'b1;
         end
      end
      o.rdata = rd_reg;
      o.ack   = ack_miss;
   endtask

   // gap length: mostly none, some short, a few long; none while calm
   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // cycle count, calm stretches and the run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 150 == 0) calm <= ($urandom_range(0, 3) == 0);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("i2c_eeprom_master_top regression: fail");
         $finish;
      end
   end

   // request driver
   tick_type    cur_tick = '0;
   tick_type    next_tick;
   bus_out_type exp_out;
   int unsigned drive_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         drive_gap <= 0;
      end else begin
         // transfer accepted: predict its bus outputs
         if (req_valid && !req_stall) begin
            predict_tick(cur_tick, exp_out);
            bus_expect_q.push_back(exp_out);
         end
         if (!req_valid || !req_stall) begin
            if (drive_gap != 0) begin
               req_valid <= 1'b0;
               drive_gap <= drive_gap - 1;
            end else if (tick_queue.size() != 0) begin
               next_tick = tick_queue.pop_front();
               cur_tick       <= next_tick;
               req_cmd_valid  <= next_tick.cmd_valid;
               req_func       <= next_tick.func;
               req_word_addr  <= next_tick.word_addr;
               req_write_data <= next_tick.write_data;
               req_sda_in     <= next_tick.sda_in;
               req_valid      <= 1'b1;
               drive_gap      <= pause_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and back-pressure
   bus_out_type got;
   bus_out_type want;
   int unsigned stall_left = 0;
   int unsigned stall_pick = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.scl   = rsp_scl_level;
            got.pull  = rsp_sda_pull_low;
            got.busy  = rsp_busy_res;
            got.done  = rsp_done_res;
            got.rdata = rsp_read_data;
            got.ack   = rsp_ack_missing;
            if (bus_expect_q.size() == 0) begin
               flag_mismatch("result transfer with no tick outstanding", got, 0);
            end else begin
               want = bus_expect_q.pop_front();
               check_field("scl_level", got.scl, want.scl);
               check_field("sda_pull_low", got.pull, want.pull);
               check_field("busy_res", got.busy, want.busy);
               check_field("done_res", got.done, want.done);
               check_field("read_data", got.rdata, want.rdata);
               check_field("ack_missing", got.ack, want.ack);
            end
            results_seen++;
         end
         if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            stall_pick = pause_len();
            rsp_stall  <= (stall_pick != 0);
            stall_left <= (stall_pick != 0) ? stall_pick - 1 : 0;
         end
      end
   end

   task automatic push_tick(input tick_type t);
      tick_queue.push_back(t);
      ticks_pushed++;
   endtask

   function automatic logic pick_sda(input sda_mode_type mode);
      case (mode)
         SDA_LOW:        return 1'b0;
         SDA_MOSTLY_LOW: return ($urandom_range(0, 15) == 0);
         SDA_RANDOM:     return 1'($urandom_range(0, 1));
         default:        return 1'b1;
      endcase
   endfunction

   // one command plus the ticks that carry it to its stop; stray commands are ignored by the block
   task automatic push_sequence(input logic [1:0] func, input logic [7:0] addr,
                                input logic [7:0] data, input sda_mode_type mode,
                                input bit stray, output int unsigned len);
      tick_type t;
      case (func)
         i2cem_pkg::FUNC_WRITE: len = 152;
         i2cem_pkg::FUNC_READ:  len = 192;
         default:               len = 12 + 4 * RECOVERY_TOGGLES;
      endcase
      t.cmd_valid  = 1'b1;
      t.func       = func;
      t.word_addr  = addr;
      t.write_data = data;
      t.sda_in     = pick_sda(mode);
      push_tick(t);
      for (int unsigned i = 1; i < len; i++) begin
         t.cmd_valid  = stray && ($urandom_range(0, 7) == 0);
         t.func       = 2'($urandom_range(0, 3));
         t.word_addr  = 8'($urandom_range(0, 255));
         t.write_data = 8'($urandom_range(0, 255));
         t.sda_in     = pick_sda(mode);
         push_tick(t);
      end
   endtask

   // tick that starts nothing: no command, or the unused function code
   task automatic push_idle_tick();
      tick_type t;
      t.cmd_valid  = 1'($urandom_range(0, 1));
      t.func       = t.cmd_valid ? FUNC_UNUSED : 2'($urandom_range(0, 3));
      t.word_addr  = 8'($urandom_range(0, 255));
      t.write_data = 8'($urandom_range(0, 255));
      t.sda_in     = 1'($urandom_range(0, 1));
      push_tick(t);
   endtask

   // mostly complete sequences with random content, some loose noise between them
   task automatic random_phase(input int unsigned budget);
      int unsigned spent;
      int unsigned len;
      int unsigned n;
      spent = 0;
      while (spent < budget) begin
         if ($urandom_range(0, 9) < 8) begin
            push_sequence(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)),
                          sda_mode_type'($urandom_range(0, 3)), 1'b1, len);
            spent += len;
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
         end else begin
            n = $urandom_range(1, 4);
         end
         for (int unsigned i = 0; i < n; i++) push_idle_tick();
         spent += n;
      end
   endtask

   // wait for every result, then tick on until the bus sequence has finished
   task automatic settle_bus();
      do begin
         while (results_seen != ticks_pushed) @(posedge clock);
         if (ph != BUS_IDLE) push_idle_tick();
      end while (ph != BUS_IDLE || results_seen != ticks_pushed);
   endtask

   // register write, then read it back
   task automatic write_device_address(input logic [7:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {i2cem_pkg::CSR_DEVICE_ADDRESS, 2'b00};
      pwdata  <= {24'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      dev_addr_model = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("device_address read-back", prdata[7:0], value);
      psel    <= 1'b0;
      penable <= 1'b0;
      n_settings++;
   endtask

   initial begin
      tick_type    t;
      int unsigned len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: unused function while idle, a tick with no command, then each
      // sequence with extreme bytes and all-acked or all-missing slave responses
      t.cmd_valid  = 1'b1;
      t.func       = FUNC_UNUSED;
      t.word_addr  = 8'hFF;
      t.write_data = 8'hFF;
      t.sda_in     = 1'b1;
      push_tick(t);
      t.cmd_valid = 1'b0;
      t.func      = i2cem_pkg::FUNC_WRITE;
      push_tick(t);
      push_sequence(i2cem_pkg::FUNC_WRITE, 8'hFF, 8'h00, SDA_LOW, 1'b0, len);
      push_sequence(i2cem_pkg::FUNC_READ, 8'h00, 8'hFF, SDA_HIGH, 1'b0, len);
      push_sequence(i2cem_pkg::FUNC_RECOVER, 8'h5A, 8'hA5, SDA_HIGH, 1'b0, len);
      push_sequence(i2cem_pkg::FUNC_WRITE, 8'h00, 8'hFF, SDA_HIGH, 1'b0, len);
      push_sequence(i2cem_pkg::FUNC_READ, 8'hFF, 8'h00, SDA_LOW, 1'b1, len);
      settle_bus();

      // random phases across device address settings, extremes included
      write_device_address(8'h00);
      random_phase(PHASE_BUDGET);
      settle_bus();
      write_device_address(8'hFE);
      random_phase(PHASE_BUDGET);
      settle_bus();
      write_device_address(8'($urandom_range(1, 253)));
      random_phase(PHASE_BUDGET);
      settle_bus();
      write_device_address(i2cem_pkg::DEVICE_ADDRESS_RESET);
      random_phase(PHASE_BUDGET);
      settle_bus();

      repeat (10) @(posedge clock);
      if (bus_expect_q.size() != 0)
         flag_mismatch("ticks left without a result", bus_expect_q.size(), 0);

      $display("covered %0d ticks: %0d writes, %0d reads, %0d recoveries, %0d ignored commands",
               results_seen, n_write, n_read, n_recover, n_ignored);
      $display("over %0d device address settings plus the reset value, %0d mismatches",
               n_settings, fail_count);
      if (fail_count == 0) begin
         $display("i2c_eeprom_master_top regression: pass");
      end else begin
         $display("i2c_eeprom_master_top regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/i2cem_pkg.sv
sv/i2c_eeprom_master_top.sv
sim/tb_top.sv
